// ===== rtl/trn_ack_pkg.sv =====
// shared types and codes of the ring node with acknowledgement
package trn_ack_pkg;

  localparam int unsigned MaxNodesDefault = 64;

  localparam int unsigned NodeIdW   = 6;
  localparam int unsigned RingSizeW = 7;
  localparam int unsigned WaitW     = 16;
  localparam int unsigned ResendW   = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned RemIdxW   = $clog2(RingSizeW + 1);

  localparam logic [WaitW-1:0] AckWaitReset  = 16'd1000;
  localparam logic [RingSizeW-1:0] RingReset = 7'd2;
  // previous node of node 0 in a two-node ring
  localparam logic [NodeIdW-1:0] PrevReset   = 6'd1;

  typedef enum logic [1:0] {
    FuncToken = 2'd0,
    FuncAck   = 2'd1,
    FuncTick  = 2'd2,
    FuncWork  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KindNone   = 2'd0,
    KindToken  = 2'd1,
    KindResend = 2'd2,
    KindAck    = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNodeId   = 2'd0,
    CfgRingSize = 2'd1,
    CfgAckWait  = 2'd2,
    CfgUnused   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    kind_e               kind;
    logic [NodeIdW-1:0]  target;
    logic                version;
    logic [ResendW-1:0]  resend_count;
    logic                version_error;
    logic                holding;
  } result_t;

endpackage

// ===== rtl/token_ring_node_with_ack_unit.sv =====
// top level of the ring node with acknowledgement and timed resend
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | func, msg_version, ack_target
//   out     | output    | out_valid_o / out_stall_i| kind, target, version, resend,
//           |           |                          | error, holding
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one beat per cycle while in_stall_o is low; each accepted beat yields one result beat
// the combinational state update is registered in the result queue, which holds two beats
// a node id or ring size write works out the previous node one bit per cycle,
// holding cfg_ready_o low and in_stall_o high until the last dividend bit is done
// otherwise in_stall_o rises only while both queue entries are taken
// reset loads node 0 defaults: version 0, holding, work running

module token_ring_node_with_ack_unit #(
  parameter int unsigned MAX_NODES = trn_ack_pkg::MaxNodesDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [trn_ack_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [trn_ack_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           func_i,
  input  logic                                 msg_version_i,
  input  logic [trn_ack_pkg::NodeIdW-1:0]      ack_target_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           out_kind_o,
  output logic [trn_ack_pkg::NodeIdW-1:0]      out_target_o,
  output logic                                 out_version_o,
  output logic [trn_ack_pkg::ResendW-1:0]      resend_count_o,
  output logic                                 version_error_o,
  output logic                                 holding_o
);

  logic                 in_beat;
  logic                 out_beat;
  logic                 q_full;
  logic                 core_busy;
  trn_ack_pkg::result_t step_res;
  trn_ack_pkg::result_t out_res;

  assign cfg_ready_o = !core_busy;
  assign in_stall_o  = q_full || core_busy;
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_beat    = out_valid_o && !out_stall_i;

  trn_ack_core #(
    .MAX_NODES(MAX_NODES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (trn_ack_pkg::cfg_idx_e'(cfg_index_i)),
    .cfg_data_i   (cfg_data_i),
    .step_i       (in_beat),
    .func_i       (trn_ack_pkg::func_e'(func_i)),
    .msg_version_i(msg_version_i),
    .ack_target_i (ack_target_i),
    .busy_o       (core_busy),
    .result_o     (step_res)
  );

  trn_ack_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_beat),
    .push_data_i(step_res),
    .full_o     (q_full),
    .valid_o    (out_valid_o),
    .pop_i      (out_beat),
    .data_o     (out_res)
  );

  assign out_kind_o      = out_res.kind;
  assign out_target_o    = out_res.target;
  assign out_version_o   = out_res.version;
  assign resend_count_o  = out_res.resend_count;
  assign version_error_o = out_res.version_error;
  assign holding_o       = out_res.holding;

  a_stall_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o || !cfg_ready_o))
    else $error("input stalled with no result queued and no remainder running");

  a_beat_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> out_valid_o)
    else $error("accepted beat did not produce a result");

  a_quiet_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == trn_ack_pkg::KindNone)
      |-> (out_target_o == '0 && !out_version_o))
    else $error("empty result carries target or version");

endmodule

// ===== rtl/trn_ack_core.sv =====
// configuration registers, node state and the per-beat state update
module trn_ack_core #(
  parameter int unsigned MAX_NODES = trn_ack_pkg::MaxNodesDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  trn_ack_pkg::cfg_idx_e                cfg_index_i,
  input  logic [trn_ack_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                                 step_i,
  input  trn_ack_pkg::func_e                   func_i,
  input  logic                                 msg_version_i,
  input  logic [trn_ack_pkg::NodeIdW-1:0]      ack_target_i,
  output logic                                 busy_o,
  output trn_ack_pkg::result_t                 result_o
);

  logic [trn_ack_pkg::NodeIdW-1:0]   node_id_q;
  logic [trn_ack_pkg::RingSizeW-1:0] ring_size_q;
  logic [trn_ack_pkg::WaitW-1:0]     ack_wait_q;

  logic                              version_q, version_d;
  logic                              owner_q, owner_d;
  logic                              acked_q, acked_d;
  logic                              waiting_q, waiting_d;
  logic                              started_q, started_d;
  logic [trn_ack_pkg::WaitW-1:0]     wait_cnt_q, wait_cnt_d;
  logic [trn_ack_pkg::ResendW-1:0]   resend_q, resend_d;

  logic                              busy_q;
  logic [trn_ack_pkg::RingSizeW:0]   rem_q;
  logic [trn_ack_pkg::RemIdxW-1:0]   rem_idx_q;
  logic [trn_ack_pkg::NodeIdW-1:0]   prev_q;
  logic [trn_ack_pkg::RingSizeW:0]   rem_shift;
  logic [trn_ack_pkg::RingSizeW:0]   rem_next;
  logic                              prev_restart;

  logic [trn_ack_pkg::RingSizeW-1:0] eff_ring;
  logic [trn_ack_pkg::RingSizeW:0]   prev_num;
  logic [trn_ack_pkg::WaitW-1:0]     limit;
  logic [trn_ack_pkg::WaitW-1:0]     wait_inc;
  logic                              first_node;
  logic                              fresh;
  logic                              load_first;

  assign first_node = (node_id_q == '0);
  assign load_first = (cfg_data_i[trn_ack_pkg::NodeIdW-1:0] == '0);

  always_comb begin
    if (ring_size_q < 7'd2) begin
      eff_ring = 7'd2;
    end else if (32'(ring_size_q) > 32'(MAX_NODES)) begin
      eff_ring = trn_ack_pkg::RingSizeW'(MAX_NODES);
    end else begin
      eff_ring = ring_size_q;
    end
  end

  assign prev_num  = {2'b00, node_id_q} + {1'b0, eff_ring} - 8'd1;
  assign limit     = (ack_wait_q == '0) ? 16'd1 : ack_wait_q;
  assign wait_inc  = wait_cnt_q + 16'd1;
  assign fresh     = first_node ? (msg_version_i == version_q)
                                : (msg_version_i != version_q);

  // previous node worked out one dividend bit per cycle after a node id or ring size write
  assign prev_restart = cfg_we_i && ((cfg_index_i == trn_ack_pkg::CfgNodeId) ||
                                     (cfg_index_i == trn_ack_pkg::CfgRingSize));
  assign rem_shift = {rem_q[trn_ack_pkg::RingSizeW-1:0], prev_num[rem_idx_q]};
  assign rem_next  = (rem_shift >= {1'b0, eff_ring}) ? (rem_shift - {1'b0, eff_ring})
                                                     : rem_shift;
  assign busy_o    = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      rem_q     <= '0;
      rem_idx_q <= '0;
      prev_q    <= trn_ack_pkg::PrevReset;
    end else if (prev_restart) begin
      busy_q    <= 1'b1;
      rem_q     <= '0;
      rem_idx_q <= trn_ack_pkg::RemIdxW'(trn_ack_pkg::RingSizeW);
    end else if (busy_q) begin
      rem_q     <= rem_next;
      rem_idx_q <= rem_idx_q - 1'b1;
      if (rem_idx_q == '0) begin
        busy_q <= 1'b0;
        prev_q <= rem_next[trn_ack_pkg::NodeIdW-1:0];
      end
    end
  end

  always_comb begin
    version_d  = version_q;
    owner_d    = owner_q;
    acked_d    = acked_q;
    waiting_d  = waiting_q;
    started_d  = started_q;
    wait_cnt_d = wait_cnt_q;
    resend_d   = resend_q;
    result_o   = '0;
    result_o.kind = trn_ack_pkg::KindNone;

    unique case (func_i)
      trn_ack_pkg::FuncToken: begin
        if (fresh) begin
          acked_d    = 1'b1;
          waiting_d  = 1'b0;
          wait_cnt_d = '0;
          owner_d    = 1'b1;
          started_d  = 1'b1;
          version_d  = first_node ? ~msg_version_i : msg_version_i;
        end
        if (owner_d) begin
          result_o.kind    = trn_ack_pkg::KindAck;
          result_o.target  = prev_q;
          result_o.version = msg_version_i;
        end
      end
      trn_ack_pkg::FuncAck: begin
        if (ack_target_i == node_id_q) begin
          if (msg_version_i == version_q) begin
            acked_d    = 1'b1;
            waiting_d  = 1'b0;
            wait_cnt_d = '0;
          end else begin
            result_o.version_error = 1'b1;
          end
        end else begin
          acked_d          = 1'b1;
          waiting_d        = 1'b0;
          wait_cnt_d       = '0;
          result_o.kind    = trn_ack_pkg::KindAck;
          result_o.target  = ack_target_i;
          result_o.version = msg_version_i;
        end
      end
      trn_ack_pkg::FuncTick: begin
        if (waiting_q) begin
          wait_cnt_d = wait_inc;
          if (wait_inc >= limit) begin
            wait_cnt_d = '0;
            if (resend_q != '1) begin
              resend_d = resend_q + 8'd1;
            end
            result_o.kind    = trn_ack_pkg::KindResend;
            result_o.version = version_q;
          end
        end
      end
      trn_ack_pkg::FuncWork: begin
        if (started_q) begin
          started_d        = 1'b0;
          owner_d          = 1'b0;
          acked_d          = 1'b0;
          waiting_d        = 1'b1;
          wait_cnt_d       = '0;
          resend_d         = '0;
          result_o.kind    = trn_ack_pkg::KindToken;
          result_o.version = version_q;
        end
      end
      default: ;
    endcase

    result_o.resend_count = resend_d;
    result_o.holding      = owner_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q   <= '0;
      ring_size_q <= trn_ack_pkg::RingReset;
      ack_wait_q  <= trn_ack_pkg::AckWaitReset;
      version_q   <= 1'b0;
      owner_q     <= 1'b1;
      started_q   <= 1'b1;
      acked_q     <= 1'b0;
      waiting_q   <= 1'b0;
      wait_cnt_q  <= '0;
      resend_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        trn_ack_pkg::CfgNodeId: begin
          node_id_q  <= cfg_data_i[trn_ack_pkg::NodeIdW-1:0];
          version_q  <= ~load_first;
          owner_q    <= load_first;
          started_q  <= load_first;
          acked_q    <= 1'b0;
          waiting_q  <= 1'b0;
          wait_cnt_q <= '0;
          resend_q   <= '0;
        end
        trn_ack_pkg::CfgRingSize: begin
          ring_size_q <= cfg_data_i[trn_ack_pkg::RingSizeW-1:0];
        end
        trn_ack_pkg::CfgAckWait: begin
          ack_wait_q <= cfg_data_i;
        end
        default: ;
      endcase
    end else if (step_i) begin
      version_q  <= version_d;
      owner_q    <= owner_d;
      acked_q    <= acked_d;
      waiting_q  <= waiting_d;
      started_q  <= started_d;
      wait_cnt_q <= wait_cnt_d;
      resend_q   <= resend_d;
    end
  end

endmodule

// ===== rtl/trn_ack_outq.sv =====
// two-entry result queue between the node logic and the output channel
module trn_ack_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  trn_ack_pkg::result_t push_data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output trn_ack_pkg::result_t data_o
);

  trn_ack_pkg::result_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      priority if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== verif/trn_ack_checker.sv =====
// checker for the ring node: predicts each result beat and compares it with the block
`timescale 1ns / 100ps

module trn_ack_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  logic [trn_ack_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trn_ack_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic [1:0]                        func_i,
  input  logic                              msg_version_i,
  input  logic [trn_ack_pkg::NodeIdW-1:0]   ack_target_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [1:0]                        out_kind_o,
  input  logic [trn_ack_pkg::NodeIdW-1:0]   out_target_o,
  input  logic                              out_version_o,
  input  logic [trn_ack_pkg::ResendW-1:0]   resend_count_o,
  input  logic                              version_error_o,
  input  logic                              holding_o,
  output int unsigned                       errors_o,
  output int unsigned                       checked_o,
  output int unsigned                       pending_o
);

  logic [trn_ack_pkg::NodeIdW-1:0]   node_id;
  logic [trn_ack_pkg::RingSizeW-1:0] ring_size;
  logic [trn_ack_pkg::WaitW-1:0]     ack_wait;

  logic                              node_ver;
  logic                              holder;
  logic                              acked;
  logic                              awaiting_ack;
  logic [trn_ack_pkg::WaitW-1:0]     tick_count;
  logic [trn_ack_pkg::ResendW-1:0]   resends;
  logic                              work_running;

  trn_ack_pkg::result_t              owed_results[$];
  trn_ack_pkg::result_t              want;
  trn_ack_pkg::result_t              got;
  trn_ack_pkg::func_e                ev;
  logic                              fresh;
  int                                ring;
  int                                prev;
  int                                limit;

  function automatic void load_node_defaults();
    node_ver     = (node_id == '0) ? 1'b0 : 1'b1;
    holder       = (node_id == '0);
    work_running = (node_id == '0);
    acked        = 1'b0;
    awaiting_ack = 1'b0;
    tick_count   = '0;
    resends      = '0;
  endfunction

  function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id   = '0;
      ring_size = trn_ack_pkg::RingReset;
      ack_wait  = trn_ack_pkg::AckWaitReset;
      load_node_defaults();
      owed_results.delete();
      errors_o  = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      // result side first: an expectation is always pushed at an earlier edge than its result
      if (out_valid_o && !out_stall_i) begin
        got = '{kind: trn_ack_pkg::kind_e'(out_kind_o), target: out_target_o,
                version: out_version_o, resend_count: resend_count_o,
                version_error: version_error_o, holding: holding_o};
        if (owed_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, kind %0d", $time, out_kind_o);
          errors_o++;
        end else begin
          want = owed_results.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("target", want.target, got.target);
          check_field("version", want.version, got.version);
          check_field("resend_count", want.resend_count, got.resend_count);
          check_field("version_error", want.version_error, got.version_error);
          check_field("holding", want.holding, got.holding);
          checked_o++;
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (trn_ack_pkg::cfg_idx_e'(cfg_index_i))
          trn_ack_pkg::CfgNodeId: begin
            node_id = cfg_data_i[trn_ack_pkg::NodeIdW-1:0];
            load_node_defaults();
          end
          trn_ack_pkg::CfgRingSize: begin
            ring_size = cfg_data_i[trn_ack_pkg::RingSizeW-1:0];
          end
          trn_ack_pkg::CfgAckWait: begin
            ack_wait = cfg_data_i[trn_ack_pkg::WaitW-1:0];
          end
          default: begin
          end
        endcase
      end

      if (in_valid_i && !in_stall_o) begin
        want = '0;
        ev = trn_ack_pkg::func_e'(func_i);
        case (ev)
          trn_ack_pkg::FuncToken: begin
            fresh = (node_id == '0) ? (msg_version_i == node_ver) : (msg_version_i != node_ver);
            if (fresh) begin
              acked        = 1'b1;
              awaiting_ack = 1'b0;
              tick_count   = '0;
              holder       = 1'b1;
              work_running = 1'b1;
              node_ver     = (node_id == '0) ? ~msg_version_i : msg_version_i;
            end
            if (holder) begin
              ring = (ring_size < 2) ? 2 :
                     (ring_size > trn_ack_pkg::MaxNodesDefault) ?
                       trn_ack_pkg::MaxNodesDefault : int'(ring_size);
              prev = (int'(node_id) + ring - 1) % ring;
              want.kind    = trn_ack_pkg::KindAck;
              want.target  = prev[trn_ack_pkg::NodeIdW-1:0];
              want.version = msg_version_i;
            end
          end
          trn_ack_pkg::FuncAck: begin
            if (ack_target_i == node_id) begin
              if (msg_version_i == node_ver) begin
                acked        = 1'b1;
                awaiting_ack = 1'b0;
                tick_count   = '0;
              end else begin
                want.version_error = 1'b1;
              end
            end else begin
              // ack for another node is passed on
              acked        = 1'b1;
              awaiting_ack = 1'b0;
              tick_count   = '0;
              want.kind    = trn_ack_pkg::KindAck;
              want.target  = ack_target_i;
              want.version = msg_version_i;
            end
          end
          trn_ack_pkg::FuncTick: begin
            if (awaiting_ack) begin
              limit = (ack_wait == '0) ? 1 : int'(ack_wait);
              tick_count = tick_count + 1'b1;
              if (int'(tick_count) >= limit) begin
                tick_count = '0;
                if (resends != '1) resends = resends + 1'b1;
                want.kind    = trn_ack_pkg::KindResend;
                want.version = node_ver;
              end
            end
          end
          default: begin
            if (work_running) begin
              work_running = 1'b0;
              holder       = 1'b0;
              acked        = 1'b0;
              awaiting_ack = 1'b1;
              tick_count   = '0;
              resends      = '0;
              want.kind    = trn_ack_pkg::KindToken;
              want.version = node_ver;
            end
          end
        endcase
        want.resend_count = resends;
        want.holding      = holder;
        owed_results.push_back(want);
      end

      pending_o = owed_results.size();
    end
  end

endmodule

// ===== verif/token_ring_node_with_ack_unit_tb.sv =====
// testbench top for the ring node: drives events and register writes, reports the verdict
`timescale 1ns / 100ps

module token_ring_node_with_ack_unit_tb;

  localparam int Phases = 6;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [trn_ack_pkg::CfgIdxW-1:0]   cfg_index_i;
  logic [trn_ack_pkg::CfgDataW-1:0]  cfg_data_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [1:0]                        func_i;
  logic                              msg_version_i;
  logic [trn_ack_pkg::NodeIdW-1:0]   ack_target_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [1:0]                        out_kind_o;
  logic [trn_ack_pkg::NodeIdW-1:0]   out_target_o;
  logic                              out_version_o;
  logic [trn_ack_pkg::ResendW-1:0]   resend_count_o;
  logic                              version_error_o;
  logic                              holding_o;

  int unsigned                       errors;
  int unsigned                       checked;
  int unsigned                       pending;

  logic [trn_ack_pkg::NodeIdW-1:0]   cur_node;
  logic [trn_ack_pkg::WaitW-1:0]     cur_wait;
  bit                                idle_on;
  bit                                saturation_done;
  int unsigned                       beats_sent;
  int unsigned                       reg_writes;

  logic [trn_ack_pkg::NodeIdW-1:0]   ph_node[Phases] = '{6'd0, 6'd3, 6'd63, 6'd1, 6'd0, 6'd37};
  logic [trn_ack_pkg::RingSizeW-1:0] ph_ring[Phases] = '{7'd2, 7'd8, 7'd64, 7'd1, 7'd64, 7'd120};
  logic [trn_ack_pkg::WaitW-1:0]     ph_wait[Phases] =
    '{16'd1, 16'd2, 16'd4, 16'd0, 16'd65535, 16'd3};

  token_ring_node_with_ack_unit uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .msg_version_i, .ack_target_i,
    .out_valid_o, .out_stall_i, .out_kind_o, .out_target_o, .out_version_o,
    .resend_count_o, .version_error_o, .holding_o
  );

  trn_ack_checker chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .msg_version_i, .ack_target_i,
    .out_valid_o, .out_stall_i, .out_kind_o, .out_target_o, .out_version_o,
    .resend_count_o, .version_error_o, .holding_o,
    .errors_o(errors), .checked_o(checked), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input trn_ack_pkg::func_e f, input logic v,
                           input logic [trn_ack_pkg::NodeIdW-1:0] tgt);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    msg_version_i <= v;
    ack_target_i  <= tgt;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_noise();
    send_beat(trn_ack_pkg::func_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              6'($urandom_range(0, 63)));
  endtask

  // hold the sender off until every outstanding result beat is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input trn_ack_pkg::cfg_idx_e idx,
                           input logic [trn_ack_pkg::CfgDataW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
    if (idx == trn_ack_pkg::CfgNodeId) cur_node = data[trn_ack_pkg::NodeIdW-1:0];
    if (idx == trn_ack_pkg::CfgAckWait) cur_wait = data;
  endtask

  // result side back-pressure
  initial begin
    int unsigned run;
    int unsigned gap;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 12);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned target;
    int unsigned ticks;
    int unsigned w;
    logic [trn_ack_pkg::CfgDataW-1:0] data;
    logic [trn_ack_pkg::NodeIdW-1:0] ack_to;

    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= trn_ack_pkg::CfgNodeId;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    func_i        <= trn_ack_pkg::FuncToken;
    msg_version_i <= 1'b0;
    ack_target_i  <= '0;
    cur_node = '0;
    cur_wait = trn_ack_pkg::AckWaitReset;
    idle_on = 1'b0;
    saturation_done = 1'b0;
    beats_sent = 0;
    reg_writes = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: node 0 straight out of reset
    send_beat(trn_ack_pkg::FuncTick, 1'b0, 6'd0);
    send_beat(trn_ack_pkg::FuncAck, 1'b0, 6'd0);
    send_beat(trn_ack_pkg::FuncAck, 1'b1, 6'd63);
    send_beat(trn_ack_pkg::FuncAck, 1'b1, 6'd0);
    send_beat(trn_ack_pkg::FuncToken, 1'b1, 6'd63);
    send_beat(trn_ack_pkg::FuncToken, 1'b0, 6'd0);
    send_beat(trn_ack_pkg::FuncToken, 1'b1, 6'd21);
    send_beat(trn_ack_pkg::FuncWork, 1'b0, 6'd0);
    send_beat(trn_ack_pkg::FuncWork, 1'b1, 6'd63);
    send_beat(trn_ack_pkg::FuncTick, 1'b0, 6'd0);
    send_beat(trn_ack_pkg::FuncAck, 1'b1, 6'd0);
    send_beat(trn_ack_pkg::FuncAck, 1'b0, 6'd0);

    // last node id beyond a two-node ring, resend on every tick
    write_reg(trn_ack_pkg::CfgAckWait, 16'd0);
    write_reg(trn_ack_pkg::CfgNodeId, 16'hFFFF);
    send_beat(trn_ack_pkg::FuncToken, 1'b0, 6'd42);
    send_beat(trn_ack_pkg::FuncWork, 1'b0, 6'd0);
    send_beat(trn_ack_pkg::FuncTick, 1'b1, 6'd0);
    send_beat(trn_ack_pkg::FuncTick, 1'b0, 6'd63);
    send_beat(trn_ack_pkg::FuncAck, 1'b1, 6'd63);
    send_beat(trn_ack_pkg::FuncAck, 1'b0, 6'd63);
    send_beat(trn_ack_pkg::FuncToken, 1'b0, 6'd0);

    // ring sizes outside the legal range
    write_reg(trn_ack_pkg::CfgRingSize, 16'd0);
    write_reg(trn_ack_pkg::CfgNodeId, 16'd1);
    send_beat(trn_ack_pkg::FuncToken, 1'b0, 6'd0);
    write_reg(trn_ack_pkg::CfgRingSize, 16'd127);
    write_reg(trn_ack_pkg::CfgNodeId, 16'd5);
    send_beat(trn_ack_pkg::FuncToken, 1'b0, 6'd0);
    send_beat(trn_ack_pkg::FuncToken, 1'b1, 6'd0);
    write_reg(trn_ack_pkg::CfgUnused, 16'hA5A5);
    send_beat(trn_ack_pkg::FuncWork, 1'b1, 6'd0);

    // random: well-formed handover episodes mixed with noise
    for (int p = 0; p < Phases; p++) begin
      data = trn_ack_pkg::CfgDataW'($urandom());
      data[trn_ack_pkg::RingSizeW-1:0] = ph_ring[p];
      write_reg(trn_ack_pkg::CfgRingSize, data);
      write_reg(trn_ack_pkg::CfgAckWait, ph_wait[p]);
      data = trn_ack_pkg::CfgDataW'($urandom());
      data[trn_ack_pkg::NodeIdW-1:0] = ph_node[p];
      write_reg(trn_ack_pkg::CfgNodeId, data);
      target = beats_sent + 200;
      while (beats_sent < target) begin
        idle_on = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 19) == 0) drain();
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) send_noise();
        end else begin
          send_beat(trn_ack_pkg::FuncToken, 1'($urandom_range(0, 1)),
                    6'($urandom_range(0, 63)));
          repeat ($urandom_range(0, 2)) send_noise();
          send_beat(trn_ack_pkg::FuncWork, 1'($urandom_range(0, 1)),
                    6'($urandom_range(0, 63)));
          w = (cur_wait == '0) ? 1 : int'(cur_wait);
          if (!saturation_done && w <= 1) begin
            ticks = 300;
            saturation_done = 1'b1;
          end else begin
            ticks = $urandom_range(0, (w * 3 + 2 > 40) ? 40 : w * 3 + 2);
          end
          repeat (ticks) send_beat(trn_ack_pkg::FuncTick, 1'($urandom_range(0, 1)),
                                   6'($urandom_range(0, 63)));
          ack_to = ($urandom_range(0, 4) != 0) ? cur_node : 6'($urandom_range(0, 63));
          send_beat(trn_ack_pkg::FuncAck, 1'($urandom_range(0, 1)), ack_to);
          repeat ($urandom_range(0, 2)) send_noise();
        end
      end
    end

    drain();
    repeat (5) @(posedge clk_i);
    $display("run covered %0d event beats, %0d register writes and %0d checked results",
             beats_sent, reg_writes, checked);
    $display("node ids, ring sizes and ack waits at and beyond their limits were used");
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
